// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the auto-repeat engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked property with an active-low reset that disables the check.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

// ===== sv/kare_pkg.sv =====
// Types and constants of the key auto-repeat engine.
`default_nettype none

package kare_pkg;

    // Action codes carried on the input request.
    localparam logic [1:0] ACT_KEY_DOWN = 2'd0;
    localparam logic [1:0] ACT_KEY_UP   = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_TICK_DIVISOR = 3'd1;
    localparam logic [2:0] REG_BIND_COUNT   = 3'd2;
    localparam logic [2:0] REG_BIND_WORD_0  = 3'd3;
    localparam logic [2:0] REG_BIND_WORD_1  = 3'd4;
    localparam logic [2:0] REG_BIND_WORD_2  = 3'd5;
    localparam logic [2:0] REG_BIND_WORD_3  = 3'd6;

    // Number of binding slots held in the binding words.
    localparam logic [3:0] NUM_BINDS = 4'd8;

    // Width of one binding word register.
    localparam int BIND_WORD_W = 57;

    // Key state codes.
    localparam logic [7:0] KS_RELEASED = 8'h00;
    localparam logic [7:0] KS_ARMED    = 8'hFE;
    localparam logic [7:0] KS_REPEAT   = 8'h01;
    localparam logic [7:0] KS_NO_DELAY = 8'hFF;
    localparam logic [7:0] KS_LAST_UP  = 8'hFD;

    // One binding as packed in a binding word, scancode in the low bits.
    typedef struct packed {
        logic [7:0] init_delay;
        logic [7:0] rep_delay;
        logic [8:0] scancode;
    } binding_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEYDN,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

`default_nettype wire

// ===== sv/key_autorepeat_engine.sv =====
// Key auto-repeat engine: per-key state memory and the binding walk.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_tvalid/s_tready  | s_tuser action, s_tdata key code
//  m_      | out       | m_tvalid/m_tready  | m_tdata binding index, m_tlast
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An active key down reads the key state, then writes it. A walking tick steps through
// binding_count bindings (count limited to eight), one binding per cycle through the key
// state memory. A stalled result output holds the walk at the firing binding until there
// is room. After reset a clearing pass over every key zeroes the key state memory; no
// request is taken until it ends, while configuration writes are always taken.
`default_nettype none
`include "assert_macros.svh"

module key_autorepeat_engine
    import kare_pkg::*;
#(
    parameter int NUM_KEYS = 512
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input requests
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,   // [8:0] key_code, rest zero
    input  wire logic [1:0]             s_tuser,   // [1:0] action
    // Results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [2:0] binding_index, rest zero
    output logic                        m_tlast,   // last firing of this tick
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [BIND_WORD_W-1:0] cfg_data
);

    localparam int KW = $clog2(NUM_KEYS);
    localparam logic [10:0] NUM_KEYS_L = 11'(NUM_KEYS);
    localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

    // Configuration registers
    logic                   enable_reg;
    logic [15:0]            tick_div_reg;
    logic [3:0]             bind_cnt_reg;
    logic [BIND_WORD_W-1:0] bind_word_reg [4];

    // Sequencer and datapath registers
    state_t          state_reg, state_next;
    logic [KW-1:0]   clr_addr_reg, clr_addr_next;
    logic [15:0]     phase_reg, phase_next;
    logic [2:0]      bind_reg, bind_next;
    binding_t        cur_bind_reg, cur_bind_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [2:0]      pend_idx_reg, pend_idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [2:0]      out_idx_reg, out_idx_next;
    logic            out_last_reg, out_last_next;
    logic [KW-1:0]   rd_addr_q_reg;
    logic            fwd_valid_reg;
    logic [KW-1:0]   fwd_addr_reg;
    logic [7:0]      fwd_data_reg;

    // Key state memory
    logic [7:0]      key_mem [NUM_KEYS];
    logic [7:0]      mem_rd_reg;
    logic            mem_we;
    logic [KW-1:0]   mem_wa;
    logic [7:0]      mem_wd;
    logic [KW-1:0]   mem_ra;

    // Combinational helpers
    logic [8:0]             s_key;
    logic                   s_accept;
    logic                   key_ok;
    logic [2:0]             sel_idx;
    logic [BIND_WORD_W-1:0] sel_word;
    binding_t               sel_bind;
    logic [7:0]             cur_state;
    logic [7:0]             new_state;
    logic                   fire;
    logic                   bind_ok;
    logic [3:0]             cnt_eff;
    logic                   bind_last;
    logic                   out_free;
    logic                   walk_stall;
    logic                   push;
    logic                   push_last;
    logic [16:0]            phase_inc;
    logic [16:0]            div_eff;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign s_key     = s_tdata[8:0];
    assign key_ok    = {2'b00, s_key} < NUM_KEYS_L;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            tick_div_reg     <= 16'd1;
            bind_cnt_reg     <= 4'd0;
            bind_word_reg[0] <= '0;
            bind_word_reg[1] <= '0;
            bind_word_reg[2] <= '0;
            bind_word_reg[3] <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ENABLE:       enable_reg       <= cfg_data[0];
                REG_TICK_DIVISOR: tick_div_reg     <= cfg_data[15:0];
                REG_BIND_COUNT:   bind_cnt_reg     <= cfg_data[3:0];
                REG_BIND_WORD_0:  bind_word_reg[0] <= cfg_data;
                REG_BIND_WORD_1:  bind_word_reg[1] <= cfg_data;
                REG_BIND_WORD_2:  bind_word_reg[2] <= cfg_data;
                REG_BIND_WORD_3:  bind_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Binding selected for the next memory read: binding 0 when idle, else the next one.
    assign sel_idx  = (state_reg == ST_WALK) ? (bind_reg + 3'd1) : 3'd0;
    assign sel_word = bind_word_reg[sel_idx[2:1]];
    assign sel_bind = sel_idx[0] ? binding_t'(sel_word[56:32]) : binding_t'(sel_word[24:0]);

    // Counts above the number of slots are limited to it.
    assign cnt_eff   = (bind_cnt_reg > NUM_BINDS) ? NUM_BINDS : bind_cnt_reg;
    assign bind_last = ({1'b0, bind_reg} + 4'd1) == cnt_eff;
    assign bind_ok   = {2'b00, cur_bind_reg.scancode} < NUM_KEYS_L;

    // Read data, with the most recent write forwarded when it hits the same key.
    assign cur_state = (fwd_valid_reg && (fwd_addr_reg == rd_addr_q_reg)) ?
                       fwd_data_reg : mem_rd_reg;

    // Per-binding state update.
    always_comb begin
        fire      = 1'b0;
        new_state = cur_state;
        if (cur_state == KS_ARMED) begin
            fire = 1'b1;
            if (cur_bind_reg.init_delay != KS_NO_DELAY) begin
                new_state = (~cur_bind_reg.init_delay) - 8'd1;
            end else if (!cur_bind_reg.rep_delay[7]) begin
                new_state = cur_bind_reg.rep_delay + 8'd1;
            end else begin
                new_state = KS_NO_DELAY;
            end
        end else if (cur_state == KS_REPEAT) begin
            fire      = 1'b1;
            new_state = cur_bind_reg.rep_delay + 8'd1;
        end else if (!cur_state[7] && (cur_state != KS_RELEASED)) begin
            new_state = cur_state - 8'd1;
        end else if (cur_state[7] && (cur_state < KS_ARMED)) begin
            new_state = (cur_state == KS_LAST_UP) ? KS_REPEAT : (cur_state + 8'd1);
        end
    end

    assign walk_stall = fire && pend_valid_reg && !out_free;

    // Phase advance, with a zero divisor taken as one.
    assign phase_inc = {1'b0, phase_reg} + 17'd1;
    assign div_eff   = (tick_div_reg == 16'd0) ? 17'd1 : {1'b0, tick_div_reg};

    // Sequencer: next state, memory port control and result hand-off.
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        phase_next      = phase_reg;
        bind_next       = bind_reg;
        cur_bind_next   = cur_bind_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = rd_addr_q_reg;
        mem_wd          = new_state;
        mem_ra          = KW'(sel_bind.scancode);

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                mem_wd        = KS_RELEASED;
                clr_addr_next = clr_addr_reg + KW'(1);
                if (clr_addr_reg == LAST_KEY) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tuser != ACT_TICK) begin
                    mem_ra = KW'(s_key);
                end
                if (s_accept) begin
                    unique case (s_tuser)
                        ACT_KEY_DOWN: begin
                            if (enable_reg && key_ok) begin
                                state_next = ST_KEYDN;
                            end
                        end
                        ACT_KEY_UP: begin
                            if (enable_reg && key_ok) begin
                                mem_we = 1'b1;
                                mem_wa = KW'(s_key);
                                mem_wd = KS_RELEASED;
                            end
                        end
                        ACT_TICK: begin
                            phase_next = (phase_inc >= div_eff) ? 16'd0 : phase_inc[15:0];
                            if ((phase_reg == 16'd0) && enable_reg && (cnt_eff != 4'd0)) begin
                                state_next    = ST_WALK;
                                bind_next     = 3'd0;
                                cur_bind_next = sel_bind;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_KEYDN: begin
                // Only a released key is armed.
                if (cur_state == KS_RELEASED) begin
                    mem_we = 1'b1;
                    mem_wd = KS_ARMED;
                end
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                if (walk_stall) begin
                    // Re-read the current key so its data is there next cycle.
                    mem_ra = KW'(cur_bind_reg.scancode);
                end else begin
                    mem_we = bind_ok;
                    if (fire && bind_ok) begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_idx_next   = bind_reg;
                    end
                    if (bind_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        bind_next     = bind_reg + 3'd1;
                        cur_bind_next = sel_bind;
                    end
                end
            end
            ST_FLUSH: begin
                // The firing still held back is the last one of this tick.
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        if (push) begin
            out_valid_next = 1'b1;
            out_idx_next   = pend_idx_reg;
            out_last_next  = push_last;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            phase_reg      <= 16'd0;
            bind_reg       <= 3'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            phase_reg      <= phase_next;
            bind_reg       <= bind_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (mem_we) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_bind_reg  <= cur_bind_next;
        pend_idx_reg  <= pend_idx_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
        rd_addr_q_reg <= mem_ra;
        if (mem_we) begin
            fwd_addr_reg <= mem_wa;
            fwd_data_reg <= mem_wd;
        end
    end

    // Key state memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= key_mem[mem_ra];
    end

    `ASSERT_PROP(a_stall_holds, aclk, aresetn, (state_reg == ST_WALK && walk_stall) |=> (state_reg == ST_WALK && $stable(bind_reg) && pend_valid_reg), "walk moved on while a firing was stalled")
    `ASSERT_PROP(a_last_drains, aclk, aresetn, (push && push_last) |=> !pend_valid_reg, "a firing remained held after the last one was sent")
    `ASSERT_NEVER(a_flush_no_write, aclk, aresetn, (state_reg == ST_FLUSH) && mem_we, "key state written while flushing")
    `ASSERT_PROP(a_push_room, aclk, aresetn, push |-> (!m_tvalid || m_tready), "result overwritten before it was taken")

endmodule

`default_nettype wire
